// ===== rtl/sparse_block_gather_address_gen_assert.svh =====
// assertion macros used by the checker
`ifndef SPARSE_BLOCK_GATHER_ADDRESS_GEN_ASSERT_SVH
`define SPARSE_BLOCK_GATHER_ADDRESS_GEN_ASSERT_SVH

// same-cycle implication
`define SBGA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SBGA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sbga_pkg.sv =====
`timescale 1ns / 1ps
package sbga_pkg;

    localparam int SLOT_W     = 16;
    localparam int BATCH_W    = 8;
    localparam int BLK_W      = 12;
    localparam int INTRA_W    = 3;
    localparam int DIM_W      = 13;
    localparam int CH_CFG_W   = 7;
    localparam int CHAN_W     = 6;
    localparam int SRC_W      = 38;
    localparam int DST_W      = 28;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int PROD_W     = 25;
    localparam int POSN_W     = 27;
    localparam int ROWLIN_W   = 21;
    localparam int PIX_W      = 34;
    localparam int QPROD_W    = 49;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_ROWS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_COLS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_ROW_OFS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_COL_OFS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS_FIRST = 3'd7;

    typedef struct packed {
        logic [DIM_W-1:0]    image_height;
        logic [DIM_W-1:0]    image_width;
        logic [CH_CFG_W-1:0] channel_count;
        logic [DIM_W-1:0]    stride_rows;
        logic [DIM_W-1:0]    stride_cols;
        logic [DIM_W-1:0]    origin_row_offset;
        logic [DIM_W-1:0]    origin_col_offset;
        logic                channels_first;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic mul;
        logic sum;
        logic bnd;
        logic row;
        logic tile;
        logic load;
        logic advance;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
    } t_dp_status;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_SUM  = 8'b0000_0100,
        S_BND  = 8'b0000_1000,
        S_ROW  = 8'b0001_0000,
        S_TILE = 8'b0010_0000,
        S_LOAD = 8'b0100_0000,
        S_RUN  = 8'b1000_0000
    } t_state;

endpackage

// ===== rtl/sbga_cfg.sv =====
`timescale 1ns / 1ps
module sbga_cfg import sbga_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_height      <= DIM_W'(1);
            r_cfg.image_width       <= DIM_W'(1);
            r_cfg.channel_count     <= CH_CFG_W'(1);
            r_cfg.stride_rows       <= DIM_W'(1);
            r_cfg.stride_cols       <= DIM_W'(1);
            r_cfg.origin_row_offset <= '0;
            r_cfg.origin_col_offset <= '0;
            r_cfg.channels_first    <= 1'b1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_IMAGE_HEIGHT:   r_cfg.image_height      <= i_cfg_data;
                CFG_IMAGE_WIDTH:    r_cfg.image_width       <= i_cfg_data;
                CFG_CHANNEL_COUNT:  r_cfg.channel_count     <= i_cfg_data[CH_CFG_W-1:0];
                CFG_STRIDE_ROWS:    r_cfg.stride_rows       <= i_cfg_data;
                CFG_STRIDE_COLS:    r_cfg.stride_cols       <= i_cfg_data;
                CFG_ORIGIN_ROW_OFS: r_cfg.origin_row_offset <= i_cfg_data;
                CFG_ORIGIN_COL_OFS: r_cfg.origin_col_offset <= i_cfg_data;
                CFG_CHANNELS_FIRST: r_cfg.channels_first    <= i_cfg_data[0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/sbga_ctrl.sv =====
`timescale 1ns / 1ps
module sbga_ctrl import sbga_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_valid,
    output logic       o_stall
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_MUL;
            S_MUL:   n_state = S_SUM;
            S_SUM:   n_state = S_BND;
            S_BND:   n_state = S_ROW;
            S_ROW:   n_state = S_TILE;
            S_TILE:  n_state = S_LOAD;
            S_LOAD:  n_state = S_RUN;
            S_RUN:   if (!i_stall && i_status.last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd.capture = (r_state == S_IDLE) && i_valid;
        o_cmd.mul     = (r_state == S_MUL);
        o_cmd.sum     = (r_state == S_SUM);
        o_cmd.bnd     = (r_state == S_BND);
        o_cmd.row     = (r_state == S_ROW);
        o_cmd.tile    = (r_state == S_TILE);
        o_cmd.load    = (r_state == S_LOAD);
        o_cmd.advance = (r_state == S_RUN) && !i_stall;
    end

    assign o_valid = (r_state == S_RUN);
    assign o_stall = (r_state != S_IDLE);

endmodule

// ===== rtl/sbga_dp.sv =====
`timescale 1ns / 1ps
module sbga_dp import sbga_pkg::*; #(
    parameter int BLOCK_H           = 8,
    parameter int BLOCK_W           = 8,
    parameter int MAX_CHANNELS      = 64,
    parameter int MAX_ACTIVE_BLOCKS = 65536
) (
    input  logic               i_clk,
    input  t_cfg               i_cfg,
    input  t_dp_cmd            i_cmd,
    input  logic [SLOT_W-1:0]  i_block_slot,
    input  logic [BATCH_W-1:0] i_batch_index,
    input  logic [BLK_W-1:0]   i_block_row,
    input  logic [BLK_W-1:0]   i_block_col,
    input  logic [INTRA_W-1:0] i_intra_row,
    input  logic [INTRA_W-1:0] i_intra_col,
    output t_dp_status         o_status,
    output logic [SRC_W-1:0]   o_source_address,
    output logic               o_in_bounds,
    output logic [DST_W-1:0]   o_dest_address,
    output logic [CHAN_W-1:0]  o_channel,
    output logic               o_last
);

    localparam int POS_W = $clog2(7 * BLOCK_W + 8);
    localparam logic [32:0]         RECIP   = 33'((64'd1 << 32) / MAX_ACTIVE_BLOCKS);
    localparam logic [SLOT_W:0]     DIV_N   = (SLOT_W + 1)'(MAX_ACTIVE_BLOCKS);
    localparam logic [31:0]         DIV_N32 = 32'(MAX_ACTIVE_BLOCKS);
    localparam logic [SLOT_W-1:0]   DIV_NS  = SLOT_W'(MAX_ACTIVE_BLOCKS);
    localparam logic [CH_CFG_W-1:0] MAX_C   = CH_CFG_W'(MAX_CHANNELS);
    localparam logic [DST_W-1:0]    RS_D    = DST_W'(BLOCK_H * BLOCK_W);
    localparam logic [POS_W-1:0]    BW_P    = POS_W'(BLOCK_W);

    // captured item
    logic [SLOT_W-1:0]   r_slot;
    logic [BATCH_W-1:0]  r_batch;
    logic [BLK_W-1:0]    r_brow;
    logic [BLK_W-1:0]    r_bcol;
    logic [INTRA_W-1:0]  r_irow;
    logic [INTRA_W-1:0]  r_icol;
    logic [CH_CFG_W-1:0] r_c;

    logic [PROD_W-1:0]   r_hprod;
    logic [PROD_W-1:0]   r_wprod;
    logic [ROWLIN_W-1:0] r_bh;
    logic [QPROD_W-1:0]  r_qprod;
    logic [POS_W-1:0]    r_pos;

    logic [POSN_W-1:0]   r_hh;
    logic [POSN_W-1:0]   r_ww;
    logic [SLOT_W-1:0]   r_qn;

    logic                r_inb;
    logic [ROWLIN_W-1:0] r_row_lin;
    logic [SLOT_W-1:0]   r_slot_mod;

    logic [PIX_W-1:0]    r_rw;
    logic [DST_W-1:0]    r_slot_rs;

    logic [PIX_W-1:0]    r_pix;
    logic [DST_W-1:0]    r_tile;

    logic [SRC_W-1:0]    r_source;
    logic                r_in_bounds;
    logic [DST_W-1:0]    r_dest;
    logic [CHAN_W-1:0]   r_channel;
    logic                r_last;

    logic [CH_CFG_W-1:0] c_eff;
    logic [SLOT_W-1:0]   rem;

    always_comb begin
        priority if (i_cfg.channel_count == '0) begin
            c_eff = CH_CFG_W'(1);
        end else if (i_cfg.channel_count > MAX_C) begin
            c_eff = MAX_C;
        end else begin
            c_eff = i_cfg.channel_count;
        end
    end

    assign rem = r_slot - r_qn;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_slot  <= i_block_slot;
            r_batch <= i_batch_index;
            r_brow  <= i_block_row;
            r_bcol  <= i_block_col;
            r_irow  <= i_intra_row;
            r_icol  <= i_intra_col;
            r_c     <= c_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_hprod <= PROD_W'(r_brow) * PROD_W'(i_cfg.stride_rows);
            r_wprod <= PROD_W'(r_bcol) * PROD_W'(i_cfg.stride_cols);
            r_bh    <= ROWLIN_W'(r_batch) * ROWLIN_W'(i_cfg.image_height);
            r_qprod <= QPROD_W'(r_slot) * QPROD_W'(RECIP);
            r_pos   <= POS_W'(r_irow) * BW_P + POS_W'(r_icol);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_hh <= {{(POSN_W - DIM_W){i_cfg.origin_row_offset[DIM_W-1]}},
                     i_cfg.origin_row_offset}
                    + POSN_W'(r_hprod) + POSN_W'(r_irow);
            r_ww <= {{(POSN_W - DIM_W){i_cfg.origin_col_offset[DIM_W-1]}},
                     i_cfg.origin_col_offset}
                    + POSN_W'(r_wprod) + POSN_W'(r_icol);
            r_qn <= SLOT_W'(r_qprod[32 +: SLOT_W] * DIV_N);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bnd) begin
            r_inb <= !r_hh[POSN_W-1] && !r_ww[POSN_W-1]
                     && (r_hh[POSN_W-2:0] < (POSN_W - 1)'(i_cfg.image_height))
                     && (r_ww[POSN_W-2:0] < (POSN_W - 1)'(i_cfg.image_width));
            r_row_lin <= r_bh + ROWLIN_W'(r_hh[DIM_W-1:0]);
            if (32'(rem) >= DIV_N32) begin
                r_slot_mod <= rem - DIV_NS;
            end else begin
                r_slot_mod <= rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.row) begin
            r_rw      <= PIX_W'(r_row_lin) * PIX_W'(i_cfg.image_width);
            r_slot_rs <= DST_W'(r_slot_mod) * RS_D;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tile) begin
            r_pix  <= r_rw + PIX_W'(r_ww[DIM_W-1:0]);
            r_tile <= r_slot_rs * DST_W'(r_c);
        end
    end

    // first beat is loaded straight into the output register, then stepped
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_source    <= r_inb ? SRC_W'(r_pix) * SRC_W'(r_c) : '0;
            r_in_bounds <= r_inb;
            r_dest      <= i_cfg.channels_first ? r_tile + DST_W'(r_pos)
                                                : r_tile + DST_W'(r_pos) * DST_W'(r_c);
            r_channel   <= '0;
            r_last      <= (r_c == CH_CFG_W'(1));
        end else if (i_cmd.advance) begin
            if (r_in_bounds) begin
                r_source <= r_source + SRC_W'(1);
            end
            r_dest    <= r_dest + (i_cfg.channels_first ? RS_D : DST_W'(1));
            r_channel <= r_channel + CHAN_W'(1);
            r_last    <= (CH_CFG_W'(r_channel) + CH_CFG_W'(2)) == r_c;
        end
    end

    assign o_status.last    = r_last;
    assign o_source_address = r_source;
    assign o_in_bounds      = r_in_bounds;
    assign o_dest_address   = r_dest;
    assign o_channel        = r_channel;
    assign o_last           = r_last;

endmodule

// ===== rtl/sparse_block_gather_address_gen.sv =====
// Sparse block gather address generator.
// Input channel (i_valid / o_stall): one beat names an active block slot, its batch,
// block row and column, and one pixel position inside the block.
// Output channel (o_valid / i_stall): one beat per channel of that pixel, carrying
// the NHWC source address, the in-bounds flag (0 means zero fill, address 0),
// the tile buffer destination address, the channel and a last flag.
// Configuration: write i_cfg_data to register i_cfg_index while i_cfg_wr_en is high,
// only while the block is idle.
// The address setup runs as a six-step multiply/add sequence (MUL, SUM, BND, ROW,
// TILE, LOAD) before the first output beat; the channel run then emits one beat per
// cycle from the output register while i_stall is low, C beats in all, C the clamped
// channel count (1..64). A new input is taken only after the last output beat.
// o_stall is high from the accepted input beat until its last output beat is taken.
// While i_stall is high the current output beat holds and the run pauses.
// Reset (synchronous, active low) returns the sequencer to idle, drops o_valid and
// restores all configuration registers to their reset values.
`timescale 1ns / 1ps
module sparse_block_gather_address_gen import sbga_pkg::*; #(
    parameter int BLOCK_H           = 8,
    parameter int BLOCK_W           = 8,
    parameter int MAX_CHANNELS      = 64,
    parameter int MAX_ACTIVE_BLOCKS = 65536
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [SLOT_W-1:0]     i_block_slot,
    input  logic [BATCH_W-1:0]    i_batch_index,
    input  logic [BLK_W-1:0]      i_block_row,
    input  logic [BLK_W-1:0]      i_block_col,
    input  logic [INTRA_W-1:0]    i_intra_row,
    input  logic [INTRA_W-1:0]    i_intra_col,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [SRC_W-1:0]      o_source_address,
    output logic                  o_in_bounds,
    output logic [DST_W-1:0]      o_dest_address,
    output logic [CHAN_W-1:0]     o_channel,
    output logic                  o_last
);

    t_cfg       cfg;
    t_dp_cmd    cmd;
    t_dp_status status;

    sbga_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sbga_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd),
        .o_valid  (o_valid),
        .o_stall  (o_stall)
    );

    sbga_dp #(
        .BLOCK_H           (BLOCK_H),
        .BLOCK_W           (BLOCK_W),
        .MAX_CHANNELS      (MAX_CHANNELS),
        .MAX_ACTIVE_BLOCKS (MAX_ACTIVE_BLOCKS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_cfg            (cfg),
        .i_cmd            (cmd),
        .i_block_slot     (i_block_slot),
        .i_batch_index    (i_batch_index),
        .i_block_row      (i_block_row),
        .i_block_col      (i_block_col),
        .i_intra_row      (i_intra_row),
        .i_intra_col      (i_intra_col),
        .o_status         (status),
        .o_source_address (o_source_address),
        .o_in_bounds      (o_in_bounds),
        .o_dest_address   (o_dest_address),
        .o_channel        (o_channel),
        .o_last           (o_last)
    );

endmodule

// ===== rtl/sbga_checker.sv =====
`timescale 1ns / 1ps
`include "sparse_block_gather_address_gen_assert.svh"
module sbga_checker import sbga_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_wr_en,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic [SLOT_W-1:0]     i_block_slot,
    input logic [BATCH_W-1:0]    i_batch_index,
    input logic [BLK_W-1:0]      i_block_row,
    input logic [BLK_W-1:0]      i_block_col,
    input logic [INTRA_W-1:0]    i_intra_row,
    input logic [INTRA_W-1:0]    i_intra_col,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [SRC_W-1:0]      o_source_address,
    input logic                  o_in_bounds,
    input logic [DST_W-1:0]      o_dest_address,
    input logic [CHAN_W-1:0]     o_channel,
    input logic                  o_last
);

    // block stays busy after taking an input beat
    `SBGA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "input not held off after accept")

    // stalled output beat holds
    `SBGA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_channel) && $stable(o_dest_address) && $stable(o_source_address), "stalled output beat changed")

    // channels count up within a run
    `SBGA_ASSERT_NEXT(a_chan_step, i_clk, i_rst_n, o_valid && !i_stall && !o_last, o_valid && (o_channel == 6'($past(o_channel) + 6'd1)), "channel did not step by one")

    // run ends after the last beat
    `SBGA_ASSERT_NEXT(a_run_end, i_clk, i_rst_n, o_valid && !i_stall && o_last, !o_valid && !o_stall, "output continued after last beat")

    // zero fill carries a zero source address
    `SBGA_ASSERT_NOW(a_zero_fill, i_clk, i_rst_n, o_valid && !o_in_bounds, o_source_address == '0, "out of bounds beat has nonzero source")

endmodule

bind sparse_block_gather_address_gen sbga_checker u_sbga_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import sbga_pkg::*;

    localparam int TILE_H        = 8;
    localparam int TILE_W        = 8;
    localparam int MAX_CH        = 64;
    localparam int DRAIN_CYCLES  = 12;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_PIXELS  = 56;
    localparam int REPORT_CAP    = 100;

    typedef enum int {
        PACE_FULL,
        PACE_SENDER_IDLE,
        PACE_RECEIVER_STALL,
        PACE_BOTH
    } t_pace;

    typedef struct {
        logic [SLOT_W-1:0]  slot;
        logic [BATCH_W-1:0] batch;
        logic [BLK_W-1:0]   brow;
        logic [BLK_W-1:0]   bcol;
        logic [INTRA_W-1:0] irow;
        logic [INTRA_W-1:0] icol;
    } t_pixel;

    typedef struct {
        logic [SRC_W-1:0]  src;
        logic              inb;
        logic [DST_W-1:0]  dst;
        logic [CHAN_W-1:0] chan;
        logic              last;
    } t_addr_beat;

    class gather_scoreboard;
        t_cfg        regs;
        t_addr_beat  expected_beats[$];
        int unsigned errors;

        function new();
            regs = '0;
            regs.image_height   = 13'd1;
            regs.image_width    = 13'd1;
            regs.channel_count  = 7'd1;
            regs.stride_rows    = 13'd1;
            regs.stride_cols    = 13'd1;
            regs.channels_first = 1'b1;
            errors = 0;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_IMAGE_HEIGHT:   regs.image_height      = data;
                CFG_IMAGE_WIDTH:    regs.image_width       = data;
                CFG_CHANNEL_COUNT:  regs.channel_count     = data[CH_CFG_W-1:0];
                CFG_STRIDE_ROWS:    regs.stride_rows       = data;
                CFG_STRIDE_COLS:    regs.stride_cols       = data;
                CFG_ORIGIN_ROW_OFS: regs.origin_row_offset = data;
                CFG_ORIGIN_COL_OFS: regs.origin_col_offset = data;
                CFG_CHANNELS_FIRST: regs.channels_first    = data[0];
                default: ;
            endcase
        endfunction

        // one pixel expands into one address beat per channel
        function void predict_pixel(t_pixel p);
            longint unsigned run_len, h, w, bat, slot, ch, tile, dst, src;
            longint row_pos, col_pos, ofs, blk, step;
            bit hit;
            t_addr_beat b;
            run_len = regs.channel_count;
            if (run_len == 0) run_len = 1;
            if (run_len > MAX_CH) run_len = MAX_CH;
            h = regs.image_height;
            w = regs.image_width;
            bat = p.batch;
            slot = p.slot;
            ofs = $signed(regs.origin_row_offset);
            blk = p.brow;
            step = regs.stride_rows;
            row_pos = ofs + blk * step + longint'(p.irow);
            ofs = $signed(regs.origin_col_offset);
            blk = p.bcol;
            step = regs.stride_cols;
            col_pos = ofs + blk * step + longint'(p.icol);
            hit = row_pos >= 0 && col_pos >= 0 &&
                  unsigned'(row_pos) < h && unsigned'(col_pos) < w;
            src = 0;
            if (hit) begin
                src = ((bat * h + unsigned'(row_pos)) * w
                       + unsigned'(col_pos)) * run_len;
            end
            tile = slot * TILE_H * TILE_W * run_len;
            for (ch = 0; ch < run_len; ch++) begin
                if (regs.channels_first) begin
                    dst = tile + ch * TILE_H * TILE_W + p.irow * TILE_W + p.icol;
                end else begin
                    dst = tile + (p.irow * TILE_W + p.icol) * run_len + ch;
                end
                b.src  = hit ? SRC_W'(src + ch) : '0;
                b.inb  = hit;
                b.dst  = DST_W'(dst);
                b.chan = CHAN_W'(ch);
                b.last = (ch == run_len - 1);
                expected_beats.push_back(b);
            end
        endfunction

        function void report(string what, logic [63:0] exp_v, logic [63:0] act_v);
            errors++;
            if (errors <= REPORT_CAP) begin
                $display("%0t %s expected %0h actual %0h", $time, what, exp_v, act_v);
            end
        endfunction

        function void check_beat(t_addr_beat got);
            t_addr_beat want;
            if (expected_beats.size() == 0) begin
                errors++;
                if (errors <= REPORT_CAP) begin
                    $display("%0t unexpected beat expected none actual source %0h dest %0h",
                             $time, got.src, got.dst);
                end
                return;
            end
            want = expected_beats.pop_front();
            if (got.src !== want.src) report("source_address", want.src, got.src);
            if (got.inb !== want.inb) report("in_bounds", want.inb, got.inb);
            if (got.dst !== want.dst) report("dest_address", want.dst, got.dst);
            if (got.chan !== want.chan) report("channel", want.chan, got.chan);
            if (got.last !== want.last) report("last", want.last, got.last);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic [SLOT_W-1:0]     i_block_slot;
    logic [BATCH_W-1:0]    i_batch_index;
    logic [BLK_W-1:0]      i_block_row;
    logic [BLK_W-1:0]      i_block_col;
    logic [INTRA_W-1:0]    i_intra_row;
    logic [INTRA_W-1:0]    i_intra_col;
    logic                  o_valid;
    logic                  i_stall;
    logic [SRC_W-1:0]      o_source_address;
    logic                  o_in_bounds;
    logic [DST_W-1:0]      o_dest_address;
    logic [CHAN_W-1:0]     o_channel;
    logic                  o_last;

    gather_scoreboard sb = new();
    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned quiet_cycles;
    t_cfg        cur_cfg;

    sparse_block_gather_address_gen dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_block_slot     (i_block_slot),
        .i_batch_index    (i_batch_index),
        .i_block_row      (i_block_row),
        .i_block_col      (i_block_col),
        .i_intra_row      (i_intra_row),
        .i_intra_col      (i_intra_col),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_source_address (o_source_address),
        .o_in_bounds      (o_in_bounds),
        .o_dest_address   (o_dest_address),
        .o_channel        (o_channel),
        .o_last           (o_last)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_stall = ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_wr_en) sb.apply_reg(i_cfg_index, i_cfg_data);
            if (i_valid && !o_stall) begin
                sb.predict_pixel(t_pixel'{i_block_slot, i_batch_index, i_block_row,
                                          i_block_col, i_intra_row, i_intra_col});
            end
            if (o_valid && !i_stall) begin
                sb.check_beat(t_addr_beat'{o_source_address, o_in_bounds, o_dest_address,
                                           o_channel, o_last});
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_wr_en) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic set_pace(input t_pace pace);
        case (pace)
            PACE_FULL:           begin idle_pct = 0;  stall_pct = 0;  end
            PACE_SENDER_IDLE:    begin idle_pct = 54; stall_pct = 0;  end
            PACE_RECEIVER_STALL: begin idle_pct = 0;  stall_pct = 54; end
            default:             begin idle_pct = 11; stall_pct = 11; end
        endcase
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
    endtask

    // upper data bits of the narrow registers are junk on purpose
    task automatic program_cfg(input t_cfg c);
        cfg_write(CFG_IMAGE_HEIGHT, c.image_height);
        cfg_write(CFG_IMAGE_WIDTH, c.image_width);
        cfg_write(CFG_CHANNEL_COUNT, {6'($urandom), c.channel_count});
        cfg_write(CFG_STRIDE_ROWS, c.stride_rows);
        cfg_write(CFG_STRIDE_COLS, c.stride_cols);
        cfg_write(CFG_ORIGIN_ROW_OFS, c.origin_row_offset);
        cfg_write(CFG_ORIGIN_COL_OFS, c.origin_col_offset);
        cfg_write(CFG_CHANNELS_FIRST, {12'($urandom), c.channels_first});
        i_cfg_wr_en = 1'b0;
        cur_cfg = c;
    endtask

    // called at a falling edge; valid stays up if the next beat follows at once
    task automatic send_pixel(input t_pixel p);
        while ($urandom_range(99) < idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_block_slot  = p.slot;
        i_batch_index = p.batch;
        i_block_row   = p.brow;
        i_block_col   = p.bcol;
        i_intra_row   = p.irow;
        i_intra_col   = p.icol;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid = 1'b0;
        while (sb.expected_beats.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic t_pixel make_pixel(int unsigned slot, int unsigned batch,
                                          int unsigned brow, int unsigned bcol,
                                          int unsigned irow, int unsigned icol);
        t_pixel p;
        p.slot  = SLOT_W'(slot);
        p.batch = BATCH_W'(batch);
        p.brow  = BLK_W'(brow);
        p.bcol  = BLK_W'(bcol);
        p.irow  = INTRA_W'(irow);
        p.icol  = INTRA_W'(icol);
        return p;
    endfunction

    function automatic logic [DIM_W-1:0] random_dim(int unsigned typ_max);
        case ($urandom_range(15))
            0:       return '0;
            1:       return DIM_W'(4096);
            2:       return '1;
            3:       return DIM_W'($urandom);
            default: return DIM_W'($urandom_range(1, typ_max));
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] random_offset();
        case ($urandom_range(11))
            0:       return DIM_W'(-4096);
            1:       return DIM_W'(4095);
            2:       return DIM_W'($urandom);
            default: return DIM_W'(int'($urandom_range(32)) - 16);
        endcase
    endfunction

    function automatic t_cfg random_cfg();
        t_cfg c;
        case ($urandom_range(19))
            0:       c.channel_count = '0;
            1:       c.channel_count = CH_CFG_W'(64);
            2:       c.channel_count = CH_CFG_W'($urandom_range(65, 127));
            3:       c.channel_count = CH_CFG_W'($urandom_range(17, 63));
            default: c.channel_count = CH_CFG_W'($urandom_range(1, 16));
        endcase
        c.image_height      = random_dim(200);
        c.image_width       = random_dim(200);
        c.stride_rows       = random_dim(16);
        c.stride_cols       = random_dim(16);
        c.origin_row_offset = random_offset();
        c.origin_col_offset = random_offset();
        c.channels_first    = 1'($urandom);
        return c;
    endfunction

    // mostly blocks near the image so that in-bounds beats are common
    function automatic logic [BLK_W-1:0] random_block(logic [DIM_W-1:0] dim,
                                                      logic [DIM_W-1:0] stride);
        int unsigned span;
        if ($urandom_range(9) < 3) return BLK_W'($urandom);
        span = dim / ((stride == 0) ? 1 : stride) + 2;
        if (span > 4095) span = 4095;
        return BLK_W'($urandom_range(0, span));
    endfunction

    function automatic t_pixel random_pixel();
        t_pixel p;
        p.slot  = SLOT_W'($urandom);
        p.batch = BATCH_W'($urandom);
        p.brow  = random_block(cur_cfg.image_height, cur_cfg.stride_rows);
        p.bcol  = random_block(cur_cfg.image_width, cur_cfg.stride_cols);
        p.irow  = INTRA_W'($urandom);
        p.icol  = INTRA_W'($urandom);
        return p;
    endfunction

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_block_slot  = '0;
        i_batch_index = '0;
        i_block_row   = '0;
        i_block_col   = '0;
        i_intra_row   = '0;
        i_intra_col   = '0;
        quiet_cycles  = 0;
        cur_cfg       = '0;
        set_pace(PACE_FULL);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset configuration
        send_pixel(make_pixel(0, 0, 0, 0, 0, 0));
        send_pixel(make_pixel(65535, 255, 4095, 4095, 7, 7));
        send_pixel(make_pixel(0, 255, 0, 0, 0, 0));

        // most negative offsets, strides of 4096, nhwc tiles
        wait_drained();
        program_cfg('{13'd4096, 13'd4096, 7'd64, 13'd4096, 13'd4096,
                      13'h1000, 13'h1000, 1'b0});
        send_pixel(make_pixel(0, 0, 0, 0, 0, 0));
        send_pixel(make_pixel(65535, 255, 1, 1, 7, 7));
        send_pixel(make_pixel(1, 3, 2, 1, 0, 0));
        send_pixel(make_pixel(2, 4, 1, 0, 0, 7));

        // zero height, zero channel count
        wait_drained();
        program_cfg('{13'd0, 13'd8191, 7'd0, 13'd1, 13'd1, 13'd0, 13'd0, 1'b1});
        send_pixel(make_pixel(0, 0, 0, 0, 0, 0));
        send_pixel(make_pixel(65535, 255, 4095, 4095, 7, 7));

        // channel count above max, largest dims and offsets
        wait_drained();
        program_cfg('{13'd8191, 13'd8191, 7'd100, 13'd8191, 13'd8191,
                      13'd4095, 13'd4095, 1'b1});
        send_pixel(make_pixel(0, 0, 0, 0, 0, 0));
        send_pixel(make_pixel(65535, 255, 0, 0, 7, 7));
        send_pixel(make_pixel(5, 9, 1, 0, 0, 0));

        // offsets of -1, zero column stride, edge pixels
        wait_drained();
        program_cfg('{13'd8, 13'd8, 7'd127, 13'd1, 13'd0, 13'h1FFF, 13'h1FFF, 1'b0});
        set_pace(PACE_BOTH);
        send_pixel(make_pixel(0, 0, 0, 0, 0, 0));
        send_pixel(make_pixel(7, 1, 1, 5, 7, 7));
        send_pixel(make_pixel(8, 2, 0, 0, 1, 1));
        send_pixel(make_pixel(9, 3, 2, 0, 7, 0));

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_drained();
            program_cfg(random_cfg());
            set_pace(t_pace'(ph % 4));
            repeat (PHASE_PIXELS) send_pixel(random_pixel());
        end

        wait_drained();
        if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sbga_pkg.sv
rtl/sbga_cfg.sv
rtl/sbga_ctrl.sv
rtl/sbga_dp.sv
rtl/sparse_block_gather_address_gen.sv
rtl/sbga_checker.sv
bench/tb.sv
